// File: rtl/oik_pkg.sv
`default_nettype none
package oik_pkg;

    // Pipeline depth, one enable per stage
    localparam int NUM_STAGES = 7;
    typedef logic [NUM_STAGES-1:0] t_stage_en;

    // Stage numbers (index into t_stage_en)
    localparam int ST_INDEX  = 0;
    localparam int ST_TABLE  = 1;
    localparam int ST_COEF   = 2;
    localparam int ST_PROD   = 3;
    localparam int ST_SUM    = 4;
    localparam int ST_SCALE  = 5;
    localparam int ST_ROUND  = 6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ROBOT_RADIUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE  = 1'd1;
    localparam logic [CFG_DATA_W-1:0] RADIUS_RESET = 16'd256;
    localparam logic [CFG_DATA_W-1:0] SCALE_RESET  = 16'd256;

    // Fixed-point constants
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [15:0] ROOT_HALF_Q14 = 16'sd11585;
    localparam logic [63:0] SINE_CAP = 64'd16384;
    localparam logic [8:0] TAYLOR_DIV [8] = '{9'd6, 9'd20, 9'd42, 9'd72,
                                             9'd110, 9'd156, 9'd210, 9'd272};

    // Datapath widths
    localparam int TRIG_W = 16;   // signed Q1.14, range +-16384
    localparam int WR_W   = 33;   // radius * yaw rate, Q18
    localparam int KC_W   = 30;   // K * (c +- s), Q28
    localparam int TERM_W = 46;   // v * K * (c +- s), Q36
    localparam int SUM_W  = 52;   // wheel sum, Q36
    localparam int Q16_W  = 32;   // rounded wheel sum, Q16
    localparam int SPROD_W = 49;  // Q16 times scale, Q24
    localparam int RND_W  = 25;   // integer motor speed before clipping

    localparam logic signed [15:0] SPEED_MAX = 16'sh7FFF;
    localparam logic signed [15:0] SPEED_MIN = 16'sh8000;

    typedef logic signed [Q16_W-1:0] t_q16;

endpackage
`default_nettype wire

// File: rtl/oik_cmd_if.sv
`default_nettype none
interface oik_cmd_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [15:0] vel_x;
    logic [15:0] vel_y;
    logic [15:0] yaw_rate;
    logic [15:0] heading;

    modport source (output valid, op, vel_x, vel_y, yaw_rate, heading, input ready);
    modport sink   (input valid, op, vel_x, vel_y, yaw_rate, heading, output ready);
endinterface
`default_nettype wire

// File: rtl/oik_res_if.sv
`default_nettype none
interface oik_res_if;
    logic        valid;
    logic        ready;
    logic [15:0] wheel_one;
    logic [15:0] wheel_two;
    logic [15:0] wheel_three;
    logic [15:0] wheel_four;
    logic        saturated;

    modport source (output valid, wheel_one, wheel_two, wheel_three, wheel_four, saturated,
                    input ready);
    modport sink   (input valid, wheel_one, wheel_two, wheel_three, wheel_four, saturated,
                    output ready);
endinterface
`default_nettype wire

// File: rtl/oik_trig.sv
`default_nettype none
module oik_trig #(
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic                            i_clk,
    input  wire oik_pkg::t_stage_en              i_en,
    input  wire logic [ANGLE_BITS-1:0]           i_angle,
    output logic signed [oik_pkg::TRIG_W-1:0]    o_sine
);

    localparam int PH_W    = ANGLE_BITS - 2;
    localparam int IDX_W   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W  = PH_W + IDX_W;

    // Quarter-wave entry, Taylor series in Q30 rounded to Q14
    function automatic logic [14:0] f_entry(input int unsigned i);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] q;
        x = (oik_pkg::HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
        term = x;
        sum = x;
        for (int n = 1; n <= 8; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'(oik_pkg::TAYLOR_DIV[n-1]);
            if (n % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        q = (sum + 64'd32768) >> 16;
        if (q > oik_pkg::SINE_CAP) begin
            q = oik_pkg::SINE_CAP;
        end
        return q[14:0];
    endfunction

    logic [14:0] w_tab [SINE_TABLE_DEPTH+1];

    for (genvar gi = 0; gi <= SINE_TABLE_DEPTH; gi++) begin : g_tab
        assign w_tab[gi] = f_entry(gi);
    end

    // Split angle into quadrant and phase, scale phase to a table index
    logic [1:0]        w_quad;
    logic [PH_W-1:0]   w_phase;
    logic [PROD_W-1:0] w_prod;
    logic [IDX_W-1:0]  w_idx;
    logic [IDX_W-1:0]  n_idx;

    assign w_quad  = i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
    assign w_phase = i_angle[PH_W-1:0];
    assign w_prod  = PROD_W'(w_phase) * PROD_W'(SINE_TABLE_DEPTH);
    assign w_idx   = w_prod[PROD_W-1:PH_W];

    // Mirror the index in odd quadrants
    always_comb begin
        if (w_quad[0]) begin
            n_idx = IDX_W'(SINE_TABLE_DEPTH) - w_idx;
        end else begin
            n_idx = w_idx;
        end
    end

    logic [IDX_W-1:0] r1_idx;
    logic             r1_neg;

    always_ff @(posedge i_clk) begin
        if (i_en[oik_pkg::ST_INDEX]) begin
            r1_idx <= n_idx;
            r1_neg <= w_quad[1];
        end
    end

    // Read the table, negate in the lower half turn
    logic signed [oik_pkg::TRIG_W-1:0] w_mag;
    assign w_mag = $signed({1'b0, w_tab[r1_idx]});

    always_ff @(posedge i_clk) begin
        if (i_en[oik_pkg::ST_TABLE]) begin
            o_sine <= r1_neg ? -w_mag : w_mag;
        end
    end

endmodule
`default_nettype wire

// File: rtl/oik_mix.sv
`default_nettype none
module oik_mix (
    input  wire logic                             i_clk,
    input  wire oik_pkg::t_stage_en               i_en,
    input  wire logic signed [oik_pkg::TRIG_W-1:0] i_sin,
    input  wire logic signed [oik_pkg::TRIG_W-1:0] i_cos,
    input  wire logic signed [15:0]               i_vx,
    input  wire logic signed [15:0]               i_vy,
    input  wire logic signed [oik_pkg::WR_W-1:0]  i_wr,
    output oik_pkg::t_q16                         o_q16 [4]
);

    localparam int SW = oik_pkg::SUM_W;

    // Stage 3: sum and difference of cos/sin, times root half
    logic signed [oik_pkg::TRIG_W:0]   w_p;
    logic signed [oik_pkg::TRIG_W:0]   w_m;
    logic signed [32:0]                w_kp_full;
    logic signed [32:0]                w_km_full;
    logic signed [oik_pkg::KC_W-1:0]   r3_kp;
    logic signed [oik_pkg::KC_W-1:0]   r3_km;
    logic signed [15:0]                r3_vx;
    logic signed [15:0]                r3_vy;
    logic signed [oik_pkg::WR_W-1:0]   r3_wr;

    assign w_p = (oik_pkg::TRIG_W + 1)'(i_cos) + (oik_pkg::TRIG_W + 1)'(i_sin);
    assign w_m = (oik_pkg::TRIG_W + 1)'(i_cos) - (oik_pkg::TRIG_W + 1)'(i_sin);
    assign w_kp_full = w_p * oik_pkg::ROOT_HALF_Q14;
    assign w_km_full = w_m * oik_pkg::ROOT_HALF_Q14;

    always_ff @(posedge i_clk) begin
        if (i_en[oik_pkg::ST_COEF]) begin
            r3_kp <= w_kp_full[oik_pkg::KC_W-1:0];
            r3_km <= w_km_full[oik_pkg::KC_W-1:0];
            r3_vx <= i_vx;
            r3_vy <= i_vy;
            r3_wr <= i_wr;
        end
    end

    // Stage 4: velocity products in Q36
    logic signed [oik_pkg::TERM_W-1:0] r4_kpx;
    logic signed [oik_pkg::TERM_W-1:0] r4_kmx;
    logic signed [oik_pkg::TERM_W-1:0] r4_kpy;
    logic signed [oik_pkg::TERM_W-1:0] r4_kmy;
    logic signed [oik_pkg::WR_W-1:0]   r4_wr;

    always_ff @(posedge i_clk) begin
        if (i_en[oik_pkg::ST_PROD]) begin
            r4_kpx <= r3_vx * r3_kp;
            r4_kmx <= r3_vx * r3_km;
            r4_kpy <= r3_vy * r3_kp;
            r4_kmy <= r3_vy * r3_km;
            r4_wr  <= r3_wr;
        end
    end

    // Stage 5: combine per wheel and round half up to Q16
    logic signed [SW-1:0] w_wr36;
    logic signed [SW-1:0] w_kpx;
    logic signed [SW-1:0] w_kmx;
    logic signed [SW-1:0] w_kpy;
    logic signed [SW-1:0] w_kmy;
    logic signed [SW-1:0] w_sum [4];
    logic signed [SW-1:0] w_rnd [4];
    localparam logic signed [SW-1:0] HALF_Q36 = SW'(1) <<< 19;

    assign w_wr36 = $signed({{(SW - oik_pkg::WR_W - 18){r4_wr[oik_pkg::WR_W-1]}},
                             r4_wr, 18'd0});
    assign w_kpx = SW'(r4_kpx);
    assign w_kmx = SW'(r4_kmx);
    assign w_kpy = SW'(r4_kpy);
    assign w_kmy = SW'(r4_kmy);

    assign w_sum[0] = w_wr36 - w_kpx + w_kmy;
    assign w_sum[1] = w_wr36 - w_kmx - w_kpy;
    assign w_sum[2] = w_wr36 + w_kpx - w_kmy;
    assign w_sum[3] = w_wr36 + w_kmx + w_kpy;

    for (genvar gw = 0; gw < 4; gw++) begin : g_round
        assign w_rnd[gw] = w_sum[gw] + HALF_Q36;

        always_ff @(posedge i_clk) begin
            if (i_en[oik_pkg::ST_SUM]) begin
                o_q16[gw] <= w_rnd[gw][oik_pkg::Q16_W+19:20];
            end
        end
    end

endmodule
`default_nettype wire

// File: rtl/oik_finish.sv
`default_nettype none
module oik_finish (
    input  wire logic                  i_clk,
    input  wire oik_pkg::t_stage_en    i_en,
    input  wire oik_pkg::t_q16         i_q16,
    input  wire logic [15:0]           i_scale,
    output logic [15:0]                o_speed,
    output logic                       o_clip
);

    localparam int PW = oik_pkg::SPROD_W;
    localparam int RW = oik_pkg::RND_W;

    // Stage 6: scale to motor units, Q24
    logic signed [PW-1:0] r6_prod;

    always_ff @(posedge i_clk) begin
        if (i_en[oik_pkg::ST_SCALE]) begin
            r6_prod <= i_q16 * $signed({1'b0, i_scale});
        end
    end

    // Stage 7: round half up to integer and clip to 16 bits
    localparam logic signed [PW-1:0] HALF_Q24 = PW'(1) <<< 23;
    localparam logic signed [RW-1:0] MAX_R = RW'(oik_pkg::SPEED_MAX);
    localparam logic signed [RW-1:0] MIN_R = RW'(oik_pkg::SPEED_MIN);
    logic signed [PW-1:0] w_rnd;
    logic signed [RW-1:0] w_int;
    logic [15:0]          n_speed;
    logic                 n_clip;

    assign w_rnd = r6_prod + HALF_Q24;
    assign w_int = w_rnd[RW+23:24];

    always_comb begin
        priority if (w_int > MAX_R) begin
            n_speed = oik_pkg::SPEED_MAX;
            n_clip  = 1'b1;
        end else if (w_int < MIN_R) begin
            n_speed = oik_pkg::SPEED_MIN;
            n_clip  = 1'b1;
        end else begin
            n_speed = w_int[15:0];
            n_clip  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[oik_pkg::ST_ROUND]) begin
            o_speed <= n_speed;
            o_clip  <= n_clip;
        end
    end

endmodule
`default_nettype wire

// File: rtl/omni_wheel_inverse_kinematics.sv
`default_nettype none
// Throughput: one command per cycle unless o_res stalls, set by the seven-stage pipeline
// (table index, sine table read, coefficient multiply, velocity multiply, sum, scale,
// round/clip). Each stage advances while it is empty or the next stage advances, so
// bubbles fill while a result waits. Reset (i_rst_n low, synchronous) empties the
// pipeline and loads robot_radius and speed_scale with 256.
module omni_wheel_inverse_kinematics #(
    parameter int ANGLE_BITS       = 16,
    parameter int SINE_TABLE_DEPTH = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [oik_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [oik_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    oik_cmd_if.sink                              i_cmd,
    oik_res_if.source                            o_res
);

    localparam int NS = oik_pkg::NUM_STAGES;
    localparam logic [ANGLE_BITS-1:0] QUARTER = {2'b01, {(ANGLE_BITS-2){1'b0}}};

    // Configuration registers
    logic [15:0] r_radius;
    logic [15:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= oik_pkg::RADIUS_RESET;
            r_scale  <= oik_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == oik_pkg::REG_ROBOT_RADIUS) begin
                r_radius <= i_cfg_data;
            end
            if (i_cfg_idx == oik_pkg::REG_SPEED_SCALE) begin
                r_scale <= i_cfg_data;
            end
        end
    end

    // Stage enables: advance when empty or when the next stage advances
    oik_pkg::t_stage_en w_en;
    logic [NS-1:0]      r_vld;

    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || o_res.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_cmd.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_cmd.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Angles for sine and cosine
    logic [ANGLE_BITS+15:0] w_head_ext;
    logic [ANGLE_BITS-1:0]  w_ang_s;
    logic [ANGLE_BITS-1:0]  w_ang_c;

    assign w_head_ext = {{ANGLE_BITS{1'b0}}, i_cmd.heading};
    assign w_ang_s    = i_cmd.op ? '0 : w_head_ext[ANGLE_BITS-1:0] + QUARTER;
    assign w_ang_c    = w_ang_s + QUARTER;

    // Stages 1 and 2: carry velocities, form radius times yaw rate
    logic signed [15:0]              r1_vx;
    logic signed [15:0]              r1_vy;
    logic signed [oik_pkg::WR_W-1:0] r1_wr;
    logic signed [15:0]              r2_vx;
    logic signed [15:0]              r2_vy;
    logic signed [oik_pkg::WR_W-1:0] r2_wr;

    always_ff @(posedge i_clk) begin
        if (w_en[oik_pkg::ST_INDEX]) begin
            r1_vx <= $signed(i_cmd.vel_x);
            r1_vy <= $signed(i_cmd.vel_y);
            r1_wr <= $signed({1'b0, r_radius}) * $signed(i_cmd.yaw_rate);
        end
        if (w_en[oik_pkg::ST_TABLE]) begin
            r2_vx <= r1_vx;
            r2_vy <= r1_vy;
            r2_wr <= r1_wr;
        end
    end

    logic signed [oik_pkg::TRIG_W-1:0] w_sin;
    logic signed [oik_pkg::TRIG_W-1:0] w_cos;

    oik_trig #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_sin (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(w_ang_s),
        .o_sine (w_sin)
    );

    oik_trig #(
        .ANGLE_BITS      (ANGLE_BITS),
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_cos (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_angle(w_ang_c),
        .o_sine (w_cos)
    );

    // Stages 3 to 5: wheel sums in Q16
    oik_pkg::t_q16 w_q16 [4];

    oik_mix u_mix (
        .i_clk(i_clk),
        .i_en (w_en),
        .i_sin(w_sin),
        .i_cos(w_cos),
        .i_vx (r2_vx),
        .i_vy (r2_vy),
        .i_wr (r2_wr),
        .o_q16(w_q16)
    );

    // Stages 6 and 7: scale, round and clip each wheel
    logic [15:0] w_speed [4];
    logic [3:0]  w_clip;

    for (genvar gw = 0; gw < 4; gw++) begin : g_wheel
        oik_finish u_finish (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_q16  (w_q16[gw]),
            .i_scale(r_scale),
            .o_speed(w_speed[gw]),
            .o_clip (w_clip[gw])
        );
    end

    assign o_res.valid       = r_vld[NS-1];
    assign o_res.wheel_one   = w_speed[0];
    assign o_res.wheel_two   = w_speed[1];
    assign o_res.wheel_three = w_speed[2];
    assign o_res.wheel_four  = w_speed[3];
    assign o_res.saturated   = |w_clip;

endmodule
`default_nettype wire

// File: rtl/oik_checker.sv
`default_nettype none
module oik_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_cmd_ready,
    input wire logic        i_res_valid,
    input wire logic        i_res_ready,
    input wire logic [15:0] i_wheel_one,
    input wire logic [15:0] i_wheel_two,
    input wire logic [15:0] i_wheel_three,
    input wire logic [15:0] i_wheel_four,
    input wire logic        i_saturated
);

    // Result held while the sink stalls
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result dropped while stalled");

    a_res_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> $stable(i_wheel_one) && $stable(i_wheel_two)
            && $stable(i_wheel_three) && $stable(i_wheel_four) && $stable(i_saturated))
        else $error("result payload changed while stalled");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // Pipeline never blocks input while the output side is free
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_res_valid || i_res_ready |-> i_cmd_ready)
        else $error("input stalled with free output");

    // Clip flag implies some wheel at a limit
    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_saturated |->
            i_wheel_one == 16'h7FFF || i_wheel_one == 16'h8000 ||
            i_wheel_two == 16'h7FFF || i_wheel_two == 16'h8000 ||
            i_wheel_three == 16'h7FFF || i_wheel_three == 16'h8000 ||
            i_wheel_four == 16'h7FFF || i_wheel_four == 16'h8000)
        else $error("saturated set with no wheel at a limit");

endmodule

bind omni_wheel_inverse_kinematics oik_checker u_oik_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cmd_ready  (i_cmd.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_wheel_one  (o_res.wheel_one),
    .i_wheel_two  (o_res.wheel_two),
    .i_wheel_three(o_res.wheel_three),
    .i_wheel_four (o_res.wheel_four),
    .i_saturated  (o_res.saturated)
);
`default_nettype wire

// File: tb/oik_tb_pkg.sv
`timescale 1ns / 100ps
package oik_tb_pkg;

    // Frame mode carried in the op field of a command
    typedef enum logic {
        FRAME_WORLD = 1'b0,
        FRAME_ROBOT = 1'b1
    } t_frame;

endpackage

// File: tb/oik_wheel_checker.sv
`timescale 1ns / 100ps
module oik_wheel_checker (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [oik_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [oik_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    oik_cmd_if                                   i_cmd,
    oik_res_if                                   i_res,
    output int                                   o_fail_count,
    output int                                   o_cmd_count,
    output int                                   o_res_count,
    output int                                   o_sat_count
);
    import oik_pkg::*;
    import oik_tb_pkg::*;

    localparam int              TABLE_DEPTH     = 256;
    localparam logic [15:0]     QUARTER_TURN    = 16'h4000;
    localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;
    localparam longint signed   SQRT_HALF_Q14   = 64'sd11585;
    localparam longint signed   ROUND_Q20       = 64'sd524288;
    localparam longint signed   ROUND_Q24       = 64'sd8388608;
    localparam longint signed   SPIN_TO_Q36     = 64'sd262144;

    typedef struct packed {
        logic [15:0] wheel_one;
        logic [15:0] wheel_two;
        logic [15:0] wheel_three;
        logic [15:0] wheel_four;
        logic        saturated;
    } t_wheel_speeds;

    int            sine_rom [0:TABLE_DEPTH];
    logic [15:0]   robot_radius;
    logic [15:0]   speed_scale;
    t_wheel_speeds owed_speeds [$];
    t_wheel_speeds want_speeds;
    t_wheel_speeds got_speeds;

    // Quarter-wave sine entry in Q1.14, from a Q30 Taylor series
    function automatic int quarter_wave_entry(int unsigned i);
        longint unsigned x, term, sum, q;
        x = (RIGHT_ANGLE_Q30 * longint'(i)) / TABLE_DEPTH;
        term = x;
        sum = x;
        for (int n = 1; n <= 8; n++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / longint'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        q = (sum + 64'd32768) >> 16;
        if (q > 64'd16384) begin
            q = 64'd16384;
        end
        return int'(q);
    endfunction

    initial begin
        for (int i = 0; i <= TABLE_DEPTH; i++) begin
            sine_rom[i] = quarter_wave_entry(i);
        end
    end

    // Table lookup with quadrant mirroring and negation, no interpolation
    function automatic longint signed sine_q14(logic [15:0] angle);
        int signed v;
        if (angle[14]) begin
            v = sine_rom[TABLE_DEPTH - int'(angle[13:6])];
        end else begin
            v = sine_rom[int'(angle[13:6])];
        end
        return angle[15] ? -longint'(v) : longint'(v);
    endfunction

    // Round Q36 surface speed to Q16, scale, round to integer and clip
    function automatic logic [15:0] motor_speed(longint signed surface_q36,
                                                inout bit clipped);
        longint signed q16, q24, rounded;
        q16 = (surface_q36 + ROUND_Q20) >>> 20;
        q24 = q16 * longint'({48'd0, speed_scale});
        rounded = (q24 + ROUND_Q24) >>> 24;
        if (rounded > 64'sd32767) begin
            clipped = 1'b1;
            rounded = 64'sd32767;
        end else if (rounded < -64'sd32768) begin
            clipped = 1'b1;
            rounded = -64'sd32768;
        end
        return rounded[15:0];
    endfunction

    function automatic t_wheel_speeds predict_wheel_speeds(t_frame frame,
                                                           logic [15:0] vel_x,
                                                           logic [15:0] vel_y,
                                                           logic [15:0] yaw,
                                                           logic [15:0] heading);
        logic [15:0]   angle;
        longint signed vx, vy, w, s, c, kp, km, spin;
        bit            clipped;
        t_wheel_speeds speeds;
        vx = longint'($signed(vel_x));
        vy = longint'($signed(vel_y));
        w  = longint'($signed(yaw));
        angle = (frame == FRAME_ROBOT) ? 16'd0 : 16'(heading + QUARTER_TURN);
        s = sine_q14(angle);
        c = sine_q14(16'(angle + QUARTER_TURN));
        kp = SQRT_HALF_Q14 * (c + s);
        km = SQRT_HALF_Q14 * (c - s);
        spin = longint'({48'd0, robot_radius}) * w * SPIN_TO_Q36;
        clipped = 1'b0;
        speeds.wheel_one   = motor_speed(spin - kp * vx + km * vy, clipped);
        speeds.wheel_two   = motor_speed(spin - km * vx - kp * vy, clipped);
        speeds.wheel_three = motor_speed(spin + kp * vx - km * vy, clipped);
        speeds.wheel_four  = motor_speed(spin + km * vx + kp * vy, clipped);
        speeds.saturated   = clipped;
        return speeds;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, got %0d",
                     $time, name, $signed(want), $signed(got));
            o_fail_count = o_fail_count + 1;
        end
    endtask

    // Track registers, queue predictions on command transfers, compare results
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            robot_radius = RADIUS_RESET;
            speed_scale  = SCALE_RESET;
            owed_speeds.delete();
            o_fail_count = 0;
            o_cmd_count <= 0;
            o_res_count <= 0;
            o_sat_count <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ROBOT_RADIUS: robot_radius = i_cfg_data;
                    REG_SPEED_SCALE:  speed_scale  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready) begin
                owed_speeds.push_back(predict_wheel_speeds(t_frame'(i_cmd.op), i_cmd.vel_x,
                                                           i_cmd.vel_y, i_cmd.yaw_rate,
                                                           i_cmd.heading));
                o_cmd_count <= o_cmd_count + 1;
            end
            if (i_res.valid && i_res.ready) begin
                got_speeds = '{i_res.wheel_one, i_res.wheel_two, i_res.wheel_three,
                               i_res.wheel_four, i_res.saturated};
                o_res_count <= o_res_count + 1;
                o_sat_count <= o_sat_count + int'(got_speeds.saturated);
                if (owed_speeds.size() == 0) begin
                    $display("%0t: result with nothing expected, got %h", $time, got_speeds);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want_speeds = owed_speeds.pop_front();
                    check_field("wheel_one", want_speeds.wheel_one, got_speeds.wheel_one);
                    check_field("wheel_two", want_speeds.wheel_two, got_speeds.wheel_two);
                    check_field("wheel_three", want_speeds.wheel_three,
                                got_speeds.wheel_three);
                    check_field("wheel_four", want_speeds.wheel_four, got_speeds.wheel_four);
                    check_field("saturated", 16'(want_speeds.saturated),
                                16'(got_speeds.saturated));
                end
            end
        end
    end

endmodule

// File: tb/tb_omni_wheel_inverse_kinematics.sv
`timescale 1ns / 100ps
module tb_omni_wheel_inverse_kinematics;
    import oik_pkg::*;
    import oik_tb_pkg::*;

    localparam int TIMEOUT_NS     = 2000000;
    localparam int PIPE_SETTLE    = NUM_STAGES + 3;
    localparam int SEGMENT_ITEMS  = 175;
    localparam int SEGMENT_COUNT  = 6;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int fail_count;
    int cmd_count;
    int res_count;
    int sat_count;
    int commands_sent;
    int settings_used;
    int src_idle_pct;
    int rcv_idle_pct;

    oik_cmd_if cmd_ch ();
    oik_res_if res_ch ();

    omni_wheel_inverse_kinematics u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch)
    );

    oik_wheel_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_cmd_count  (cmd_count),
        .o_res_count  (res_count),
        .o_sat_count  (sat_count)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result channel at the current rate
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            res_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("omni_wheel_inverse_kinematics verification failed");
        $finish;
    end

    // Velocity or yaw value: mostly full range, some small, some extremes
    function automatic logic [15:0] pick_signed_field();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'h0000;
                    3:       return 16'h0001;
                    default: return 16'hFFFF;
                endcase
            end
            1, 2:    return 16'($urandom_range(0, 512) - 256);
            default: return 16'($urandom);
        endcase
    endfunction

    // Heading: mostly random, some right at the quadrant boundaries
    function automatic logic [15:0] pick_heading();
        if ($urandom_range(0, 3) == 0) begin
            return 16'(($urandom_range(0, 3) << 14) + $urandom_range(0, 2) - 1);
        end
        return 16'($urandom);
    endfunction

    // Present one command after an optional gap and hold it until transfer
    task automatic send_command(t_frame frame, logic [15:0] vx, logic [15:0] vy,
                                logic [15:0] yaw, logic [15:0] hd);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        cmd_ch.valid    <= 1'b1;
        cmd_ch.op       <= frame;
        cmd_ch.vel_x    <= vx;
        cmd_ch.vel_y    <= vy;
        cmd_ch.yaw_rate <= yaw;
        cmd_ch.heading  <= hd;
        do @(posedge i_clk); while (!cmd_ch.ready);
        commands_sent++;
    endtask

    // Drop valid and wait for every owed result plus a settling margin set by PIPE_SETTLE
    task automatic drain_pipeline();
        cmd_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (cmd_count != res_count) @(posedge i_clk);
        repeat (PIPE_SETTLE) @(posedge i_clk);
    endtask

    // Write both registers while the block is idle
    task automatic apply_settings(logic [15:0] radius, logic [15:0] scale);
        drain_pipeline();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_ROBOT_RADIUS;
        i_cfg_data <= radius;
        @(posedge i_clk);
        i_cfg_idx  <= REG_SPEED_SCALE;
        i_cfg_data <= scale;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        settings_used++;
    endtask

    initial begin
        commands_sent = 0;
        settings_used = 0;
        src_idle_pct  = 6;
        rcv_idle_pct  = 65;
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_ROBOT_RADIUS;
        i_cfg_data      <= '0;
        cmd_ch.valid    <= 1'b0;
        cmd_ch.op       <= FRAME_WORLD;
        cmd_ch.vel_x    <= '0;
        cmd_ch.vel_y    <= '0;
        cmd_ch.yaw_rate <= '0;
        cmd_ch.heading  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: field extremes, both frames, heading at quadrant edges
        apply_settings(16'd256, 16'd256);
        send_command(FRAME_WORLD, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_command(FRAME_ROBOT, 16'h7FFF, 16'h0000, 16'h0000, 16'h1234);
        send_command(FRAME_ROBOT, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
        send_command(FRAME_ROBOT, 16'h0000, 16'h7FFF, 16'h0000, 16'h0000);
        send_command(FRAME_ROBOT, 16'h0000, 16'h8000, 16'h0000, 16'h0000);
        send_command(FRAME_ROBOT, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        send_command(FRAME_ROBOT, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
        send_command(FRAME_WORLD, 16'h0100, 16'h0000, 16'h0000, 16'h0000);
        send_command(FRAME_WORLD, 16'h0100, 16'h0080, 16'h0000, 16'h3FFF);
        send_command(FRAME_WORLD, 16'h0100, 16'h0080, 16'h0000, 16'h4000);
        send_command(FRAME_WORLD, 16'h0100, 16'h0080, 16'h0000, 16'h7FFF);
        send_command(FRAME_WORLD, 16'h0100, 16'h0080, 16'h0000, 16'h8000);
        // quarter turn brings these up to or past a full turn
        send_command(FRAME_WORLD, 16'h0100, 16'h0080, 16'h0000, 16'hBFFF);
        send_command(FRAME_WORLD, 16'h0100, 16'h0080, 16'h0000, 16'hC000);
        send_command(FRAME_WORLD, 16'h0100, 16'h0080, 16'h0000, 16'hFFFF);
        send_command(FRAME_WORLD, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h2000);
        send_command(FRAME_WORLD, 16'h8000, 16'h8000, 16'h8000, 16'hA000);
        send_command(FRAME_ROBOT, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hFFFF);
        // largest gains clip both ways
        apply_settings(16'hFFFF, 16'hFFFF);
        send_command(FRAME_ROBOT, 16'h0000, 16'h0000, 16'h7FFF, 16'h0000);
        send_command(FRAME_ROBOT, 16'h0000, 16'h0000, 16'h8000, 16'h0000);
        send_command(FRAME_WORLD, 16'h0001, 16'hFFFF, 16'h0000, 16'h6000);
        // zero gains give zero speeds
        apply_settings(16'h0000, 16'h0000);
        send_command(FRAME_WORLD, 16'h7FFF, 16'h8000, 16'h7FFF, 16'hE000);

        // Random segments, idle mode changing every two segments
        for (int seg = 0; seg < SEGMENT_COUNT; seg++) begin
            src_idle_pct = (seg < 2) ? 6 : (seg < 4) ? 65 : 0;
            rcv_idle_pct = (seg < 2) ? 65 : (seg < 4) ? 6 : 0;
            case (seg)
                0:       apply_settings(16'd256, 16'd256);
                1:       apply_settings(16'd0, 16'hFFFF);
                2:       apply_settings(16'hFFFF, 16'd1);
                3:       apply_settings(16'($urandom), 16'($urandom));
                4:       apply_settings(16'hFFFF, 16'hFFFF);
                default: apply_settings(16'($urandom_range(1, 1024)),
                                        16'($urandom_range(1, 1024)));
            endcase
            repeat (SEGMENT_ITEMS) begin
                send_command(t_frame'($urandom_range(0, 1)), pick_signed_field(),
                             pick_signed_field(), pick_signed_field(), pick_heading());
            end
        end

        drain_pipeline();
        $display("Sent %0d commands under %0d register settings; %0d results compared",
                 commands_sent, settings_used, res_count);
        $display("%0d results reported at least one clipped wheel", sat_count);
        if (fail_count == 0) begin
            $display("omni_wheel_inverse_kinematics verification clean");
        end else begin
            $display("omni_wheel_inverse_kinematics verification failed");
        end
        $finish;
    end

endmodule
